// ----- design/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted-array priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int ValueWidth = 32;
   localparam int CountOutWidth = 8;

   typedef logic signed [ValueWidth-1:0] spq_value_type;
   typedef logic [CountOutWidth-1:0] spq_count_out_type;

   // request action codes
   typedef enum logic {
      ACT_ENQUEUE = 1'b0,
      ACT_DEQUEUE = 1'b1
   } spq_action_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } spq_status_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic          enq;
      logic          deq;
      spq_value_type value;
   } spq_cmd_type;

endpackage

// ----- design/spq_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: one enqueue or dequeue request per handshake.
// ----------------------------------------------------------------------------
interface spq_req_if;
   import spq_pkg::*;

   logic           valid;
   logic           ready;
   logic           action;
   spq_value_type  item_value;

   modport source (output valid, output action, output item_value, input ready);
   modport sink (input valid, input action, input item_value, output ready);
endinterface

// ----- design/spq_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel: one result per accepted request.
// ----------------------------------------------------------------------------
interface spq_rsp_if;
   import spq_pkg::*;

   logic               valid;
   logic               ready;
   spq_value_type      popped_value;
   logic               popped_valid;
   logic [1:0]         status;
   spq_value_type      head_value;
   spq_count_out_type  entry_count;

   modport source (output valid, output popped_value, output popped_valid,
                   output status, output head_value, output entry_count,
                   input ready);
   modport sink (input valid, input popped_value, input popped_valid,
                 input status, input head_value, input entry_count,
                 output ready);
endinterface

// ----- design/spq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it against the
// incoming value and takes its own, the new or a neighbor's value.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::spq_cmd_type  cmd,
   input  logic                  occupied,
   input  logic                  left_keep,
   input  spq_pkg::spq_value_type left_value,
   input  spq_pkg::spq_value_type right_value,
   output spq_pkg::spq_value_type value,
   output logic                  keep
);
   import spq_pkg::*;

   spq_value_type value_ff;
   spq_value_type value_in;

   // entry stays put on enqueue when it is stored and not smaller
   assign keep = occupied && (value_ff >= cmd.value);

   // next entry: hold, take new value, shift from head side or tail side
   always_comb begin
      value_in = value_ff;
      if (cmd.enq) begin
         if (!keep) begin
            value_in = left_keep ? cmd.value : left_value;
         end
      end else if (cmd.deq) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ----- design/sorted_array_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Max-priority queue held as a descending chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  channel   dir   payload
//  req_ch    in    action, item_value
//  rsp_ch    out   popped_value, popped_valid, status, head_value, entry_count
//
//  One request per cycle: every cell compares and shifts in the cycle the
//  request is taken, and the result lands in the output register.
//  A new request is taken while the output register is empty or being read.
//  Synchronous reset clears the count and the output valid; entries are
//  never read beyond the count, so they need no clearing.
//  When the response side stalls, requests stall with it.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue #(
   parameter int QUEUE_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   spq_req_if.sink     req_ch,
   spq_rsp_if.source   rsp_ch
);
   import spq_pkg::*;

   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;

   logic              rsp_valid_ff;
   spq_value_type     popped_value_ff;
   logic              popped_valid_ff;
   spq_status_type    status_ff;
   spq_value_type     head_value_ff;
   spq_count_out_type entry_count_ff;

   spq_value_type     head_in;
   spq_status_type    status_in;

   logic        accept;
   logic        full;
   logic        empty;
   spq_cmd_type cmd;

   spq_value_type cell_value [QUEUE_DEPTH];
   logic          cell_keep [QUEUE_DEPTH];

   // handshake
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept = req_ch.valid && req_ch.ready;

   assign full  = (count_ff == CountWidth'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   // command broadcast to the chain
   assign cmd.enq   = accept && (req_ch.action == ACT_ENQUEUE) && !full;
   assign cmd.deq   = accept && (req_ch.action == ACT_DEQUEUE) && !empty;
   assign cmd.value = req_ch.item_value;

   // cell chain
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic          left_keep;
      spq_value_type left_value;
      spq_value_type right_value;
      logic          occupied;

      assign occupied = (CountWidth'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_keep  = 1'b0;
         assign left_value = cmd.value;
      end else begin : g_mid
         assign left_keep  = cell_keep[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_value = '0;
      end else begin : g_body
         assign right_value = cell_value[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (occupied),
         .left_keep   (left_keep),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i]),
         .keep        (cell_keep[i])
      );
   end

   // count, status and head after this request
   always_comb begin
      count_in  = count_ff;
      status_in = ST_OK;
      head_in   = empty ? '0 : cell_value[0];
      if (cmd.enq) begin
         count_in = count_ff + 1'b1;
         if (empty || (cmd.value > cell_value[0])) begin
            head_in = cmd.value;
         end
      end else if (cmd.deq) begin
         count_in = count_ff - 1'b1;
         head_in  = (count_ff > CountWidth'(1)) ? cell_value[1] : '0;
      end else if (req_ch.action == ACT_ENQUEUE) begin
         status_in = ST_FULL;
      end else begin
         status_in = ST_EMPTY;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         popped_value_ff <= cmd.deq ? cell_value[0] : '0;
         popped_valid_ff <= cmd.deq;
         status_ff       <= status_in;
         head_value_ff   <= head_in;
         entry_count_ff  <= CountOutWidth'(count_in);
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.popped_value = popped_value_ff;
   assign rsp_ch.popped_valid = popped_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.head_value   = head_value_ff;
   assign rsp_ch.entry_count  = entry_count_ff;

endmodule

// ----- test/tb_sorted_array_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_array_priority_queue
// Self-checking bench for the sorted-array max-priority queue. A directed
// opening covers value extremes, ties, an empty dequeue and an ignored
// dequeue value. Random phases then fill the queue to full, churn it and
// drain it to empty, under changing idle patterns and one long response
// stall. Every response is checked field by field against a behavioral copy
// of the queue that is updated at request acceptance.
// ----------------------------------------------------------------------------
module tb_sorted_array_priority_queue;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH = 128;
   localparam int CLK_HALF    = 4;
   localparam int SEG_LEN     = 220;
   localparam int LONG_HOLD   = 300;
   localparam int STALL_LIMIT = 2000;

   // one request as queued for the driver
   typedef struct packed {
      spq_action_type action;
      spq_value_type  value;
   } queue_op_type;

   // one predicted response
   typedef struct packed {
      spq_value_type     popped_value;
      logic              popped_valid;
      spq_status_type    status;
      spq_value_type     head_value;
      spq_count_out_type entry_count;
   } queue_outcome_type;

   logic clock;
   logic reset;

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();

   sorted_array_priority_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // behavioral copy of the queue contents, head at index 0
   spq_value_type     sorted_vals [QUEUE_DEPTH];
   int                held_count;

   queue_op_type      op_backlog [$];
   queue_outcome_type op_outcomes [$];
   queue_op_type      next_op;
   queue_outcome_type want;

   int             req_idle_pct;
   int             rsp_idle_pct;
   logic           hold_req;
   logic           hold_taken;
   int             hold_left;
   int             stall_cycles;
   int             mismatch_count;

   // clock
   always begin
      #CLK_HALF clock = ~clock;
   end

   // apply one request to the behavioral queue and return its response
   function automatic queue_outcome_type apply_queue_op(spq_action_type act,
                                                        spq_value_type val);
      queue_outcome_type res;
      int                pos;
      logic              found;
      res = '0;
      res.status = ST_OK;
      if (act == ACT_ENQUEUE) begin
         if (held_count >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            // insert ahead of the first strictly smaller entry
            pos = held_count;
            found = 1'b0;
            for (int k = 0; k < held_count; k++) begin
               if (!found && sorted_vals[k] < val) begin
                  pos = k;
                  found = 1'b1;
               end
            end
            for (int k = held_count; k > pos; k--)
               sorted_vals[k] = sorted_vals[k-1];
            sorted_vals[pos] = val;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.popped_value = sorted_vals[0];
            res.popped_valid = 1'b1;
            for (int k = 0; k + 1 < held_count; k++)
               sorted_vals[k] = sorted_vals[k+1];
            held_count--;
         end
      end
      res.head_value  = (held_count > 0) ? sorted_vals[0] : '0;
      res.entry_count = held_count[CountOutWidth-1:0];
      return res;
   endfunction

   // random value: full range, tight range for ties, or an extreme
   function automatic spq_value_type pick_value();
      spq_value_type v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = $urandom();
         4, 5, 6:    v = $urandom_range(8) - 4;
         7: begin
            case ($urandom_range(3))
               0:       v = 32'h7fff_ffff;
               1:       v = 32'h8000_0000;
               2:       v = 32'h0000_0000;
               default: v = 32'hffff_ffff;
            endcase
         end
         default:    v = $urandom_range(40) - 20;
      endcase
      return v;
   endfunction

   task automatic add_op(spq_action_type act, spq_value_type val);
      queue_op_type op;
      op.action = act;
      op.value  = val;
      op_backlog.push_back(op);
   endtask

   // random segment; enq_pct sets the drift toward full or empty
   task automatic add_segment(int enq_pct);
      for (int i = 0; i < SEG_LEN; i++) begin
         if ($urandom_range(99) < enq_pct)
            add_op(ACT_ENQUEUE, pick_value());
         else
            add_op(ACT_DEQUEUE, $urandom());
      end
   endtask

   // sender holds off until every request has been answered
   task automatic wait_drained();
      while (op_backlog.size() != 0 || req_ch.valid || op_outcomes.size() != 0)
         @(posedge clock);
   endtask

   task automatic flag_field(string name, logic [31:0] exp_val, logic [31:0] got);
      if (got !== exp_val) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, got);
         mismatch_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            op_outcomes.push_back(apply_queue_op(spq_action_type'(req_ch.action),
                                                 req_ch.item_value));
         if (!req_ch.valid || req_ch.ready) begin
            if (op_backlog.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               next_op = op_backlog.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.action     <= next_op.action;
               req_ch.item_value <= next_op.value;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response ready, with one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
         hold_taken   <= 1'b0;
      end else if (hold_req && !hold_taken) begin
         hold_left    <= LONG_HOLD;
         hold_taken   <= 1'b1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (op_outcomes.size() == 0) begin
            $display("%0t: response with none expected, expected nothing, got %h %b %h %h %h",
                     $time, rsp_ch.popped_value, rsp_ch.popped_valid, rsp_ch.status,
                     rsp_ch.head_value, rsp_ch.entry_count);
            mismatch_count++;
         end else begin
            want = op_outcomes.pop_front();
            flag_field("popped_value", want.popped_value, rsp_ch.popped_value);
            flag_field("popped_valid", want.popped_valid, rsp_ch.popped_valid);
            flag_field("status", want.status, rsp_ch.status);
            flag_field("head_value", want.head_value, rsp_ch.head_value);
            flag_field("entry_count", want.entry_count, rsp_ch.entry_count);
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL sorted_array_priority_queue");
            $finish;
         end
      end
   end

   // stimulus sequencing and final verdict
   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.action     = ACT_ENQUEUE;
      req_ch.item_value = '0;
      rsp_ch.ready      = 1'b0;
      hold_req          = 1'b0;
      held_count        = 0;
      mismatch_count    = 0;
      req_idle_pct      = 19;
      rsp_idle_pct      = 47;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty dequeue, extremes, zero and negatives, ties
      add_op(ACT_DEQUEUE, 32'h1234_5678);
      add_op(ACT_ENQUEUE, 32'h0000_0000);
      add_op(ACT_ENQUEUE, 32'hffff_ffff);
      add_op(ACT_ENQUEUE, 32'h7fff_ffff);
      add_op(ACT_ENQUEUE, 32'h8000_0000);
      add_op(ACT_ENQUEUE, 32'd5);
      add_op(ACT_ENQUEUE, 32'd5);
      add_op(ACT_ENQUEUE, 32'hffff_ffff);
      add_op(ACT_ENQUEUE, 32'h8000_0000);
      add_op(ACT_ENQUEUE, 32'h7fff_ffff);
      add_op(ACT_DEQUEUE, 32'hffff_ffff);
      add_op(ACT_DEQUEUE, 32'h0000_0000);
      add_op(ACT_ENQUEUE, 32'd6);
      for (int i = 0; i < 9; i++)
         add_op(ACT_DEQUEUE, $urandom());
      add_op(ACT_DEQUEUE, 32'h8000_0000);
      add_op(ACT_ENQUEUE, 32'h8000_0000);
      add_op(ACT_DEQUEUE, 32'h0000_0000);
      wait_drained();

      // random phases: fill to full, churn, drain to empty
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 19;
               rsp_idle_pct = 47;
            end
            1: begin
               req_idle_pct = 47;
               rsp_idle_pct = 19;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
               // long response stall while requests keep coming
               hold_req = 1'b1;
            end
         endcase
         add_segment(95);
         add_segment(50);
         add_segment(5);
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && op_outcomes.size() == 0) begin
         $display("PASS sorted_array_priority_queue");
      end else begin
         $display("FAIL sorted_array_priority_queue");
      end
      $finish;
   end

endmodule
